// ----- design/luiter_pkg.sv -----
// ----------------------------------------------------------------------------
// luiter_pkg
// Shared types, constants, a saturating add and a magnitude helper for the
// iterative lens undistortion pipeline.
// ----------------------------------------------------------------------------
package luiter_pkg;

    // signed working value, 28 fraction bits, bounded to +-(2^62 - 1)
    typedef logic signed [63:0] work_t;

    localparam work_t WLIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam work_t WONE = 64'sh0000_0000_1000_0000;

    // pipeline depths
    localparam int MUL_LAT   = 3;
    localparam int RECIP_QW  = 57;
    localparam int ITER_LAT  = 17 + RECIP_QW;
    localparam int NORM_QW   = 61;
    localparam int NORM_LAT  = NORM_QW + 3;
    localparam int PIX_LAT   = MUL_LAT + 2;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_K1 = 3'd0,
        REG_K2 = 3'd1,
        REG_P1 = 3'd2,
        REG_P2 = 3'd3,
        REG_FX = 3'd4,
        REG_FY = 3'd5,
        REG_CX = 3'd6,
        REG_CY = 3'd7
    } reg_idx_t;

    // saturating add of two bounded working values
    function automatic work_t sadd(input work_t a, input work_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'(WLIM))
            return WLIM;
        else if (s < -65'(WLIM))
            return -WLIM;
        else
            return s[63:0];
    endfunction

    // magnitude of a bounded working value
    function automatic logic [61:0] mag62(input work_t a);
        work_t m;
        m = a[63] ? -a : a;
        return m[61:0];
    endfunction

endpackage

// ----- design/luiter_delay.sv -----
// ----------------------------------------------------------------------------
// luiter_delay
// Enabled shift register that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module luiter_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] pipe_reg [D];

    // shift one tap per advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < D; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[D-1];

endmodule

// ----- design/luiter_mul.sv -----
// ----------------------------------------------------------------------------
// luiter_mul
// Three-stage working-format multiply: 31x31 partial products, sum with
// rounding offset, then shift by 28 with saturation and sign.
// ----------------------------------------------------------------------------
module luiter_mul
    import luiter_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  work_t a,
    input  work_t b,
    output work_t p
);

    logic [61:0]  ua, ub;
    logic [61:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic         neg1_reg, neg2_reg;
    logic [123:0] sum_reg;
    logic [95:0]  rnd;
    logic [61:0]  rmag;
    work_t        pm;
    work_t        p_reg;

    assign ua = mag62(a);
    assign ub = mag62(b);

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg  <= 62'(ua[30:0])  * 62'(ub[30:0]);
            p01_reg  <= 62'(ua[30:0])  * 62'(ub[61:31]);
            p10_reg  <= 62'(ua[61:31]) * 62'(ub[30:0]);
            p11_reg  <= 62'(ua[61:31]) * 62'(ub[61:31]);
            neg1_reg <= a[63] ^ b[63];
        end
    end

    // full product plus half lsb of the result
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= {p11_reg, 62'b0}
                      + ((124'(p01_reg) + 124'(p10_reg)) << 31)
                      + 124'(p00_reg) + (124'd1 << 27);
            neg2_reg <= neg1_reg;
        end
    end

    // scale, saturate, sign
    assign rnd  = sum_reg[123:28];
    assign rmag = (|rnd[95:62]) ? WLIM[61:0] : rnd[61:0];
    assign pm   = work_t'({2'b00, rmag});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= neg2_reg ? -pm : pm;
        end
    end

    assign p = p_reg;

endmodule

// ----- design/luiter_div.sv -----
// ----------------------------------------------------------------------------
// luiter_div
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module luiter_div #(
    parameter int NW = 62,
    parameter int DW = 62,
    parameter int QW = 57
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int XW = NW + DW;

    logic [XW-1:0] numx;
    logic [DW-1:0] rem_s [QW+1];
    logic [QW-1:0] low_s [QW+1];
    logic [QW-1:0] quo_s [QW+1];
    logic [DW-1:0] den_s [QW+1];

    // leading dividend bits form the first partial remainder
    assign numx     = XW'(num);
    assign rem_s[0] = DW'(numx >> QW);
    assign low_s[0] = num[QW-1:0];
    assign quo_s[0] = '0;
    assign den_s[0] = den;

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_step
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;
            logic [DW-1:0] rem_reg;
            logic [QW-1:0] low_reg;
            logic [QW-1:0] quo_reg;
            logic [DW-1:0] den_reg;

            // compare and subtract
            assign trial = {rem_s[s], low_s[s][QW-1]};
            assign diff  = trial - {1'b0, den_s[s]};
            assign ge    = trial >= {1'b0, den_s[s]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    low_reg <= {low_s[s][QW-2:0], 1'b0};
                    quo_reg <= {quo_s[s][QW-2:0], ge};
                    den_reg <= den_s[s];
                end
            end

            assign rem_s[s+1] = rem_reg;
            assign low_s[s+1] = low_reg;
            assign quo_s[s+1] = quo_reg;
            assign den_s[s+1] = den_reg;
        end
    endgenerate

    assign quo = quo_s[QW];

endmodule

// ----- design/luiter_iter.sv -----
// ----------------------------------------------------------------------------
// luiter_iter
// One pipelined fixed-point undistortion round: radius, radial polynomial,
// tangential terms, reciprocal of the radial factor and the final scaling.
// ----------------------------------------------------------------------------
module luiter_iter
    import luiter_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  work_t k1,
    input  work_t k2,
    input  work_t p1,
    input  work_t p2,
    input  work_t x_in,
    input  work_t y_in,
    input  work_t x0_in,
    input  work_t y0_in,
    output work_t x_out,
    output work_t y_out,
    output work_t x0_out,
    output work_t y0_out
);

    work_t        xx, yy, xy;
    work_t        r2_reg, xy2_reg, xx2_reg, yy2_reg;
    work_t        tx_reg, ty_reg, xy2d_reg;
    work_t        k2r2, s_reg, poly;
    logic [63:0]  r2_d;
    work_t        ma, mb, mc, mdp;
    work_t        ddx_reg, ddy_reg;
    logic [127:0] org_d, org_out;
    work_t        ex_reg, ey_reg;
    work_t        den_reg;
    logic [61:0]  num_reg, dvs_reg;
    logic [1:0]   flg_reg, flg_d;
    logic [56:0]  q;
    work_t        qw;
    work_t        icd_reg;
    logic [127:0] e_d;
    logic [61:0]  dmag;

    // squares and cross product
    luiter_mul u_xx (.clk(clk), .en(en), .a(x_in), .b(x_in), .p(xx));
    luiter_mul u_yy (.clk(clk), .en(en), .a(y_in), .b(y_in), .p(yy));
    luiter_mul u_xy (.clk(clk), .en(en), .a(x_in), .b(y_in), .p(xy));

    // radius and doubled terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg  <= sadd(xx, yy);
            xy2_reg <= sadd(xy, xy);
            xx2_reg <= sadd(xx, xx);
            yy2_reg <= sadd(yy, yy);
        end
    end

    // tangential sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg   <= sadd(r2_reg, xx2_reg);
            ty_reg   <= sadd(r2_reg, yy2_reg);
            xy2d_reg <= xy2_reg;
        end
    end

    // radial polynomial
    luiter_mul u_k2 (.clk(clk), .en(en), .a(k2), .b(r2_reg), .p(k2r2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= sadd(k2r2, k1);
        end
    end

    luiter_delay #(.W(64), .D(MUL_LAT + 1)) u_r2d (
        .clk(clk), .en(en), .din(r2_reg), .dout(r2_d)
    );

    luiter_mul u_poly (.clk(clk), .en(en), .a(s_reg), .b($signed(r2_d)), .p(poly));

    // tangential products
    luiter_mul u_ma (.clk(clk), .en(en), .a(p1), .b(xy2d_reg), .p(ma));
    luiter_mul u_mb (.clk(clk), .en(en), .a(p2), .b(tx_reg),   .p(mb));
    luiter_mul u_mc (.clk(clk), .en(en), .a(p1), .b(ty_reg),   .p(mc));
    luiter_mul u_md (.clk(clk), .en(en), .a(p2), .b(xy2d_reg), .p(mdp));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ddx_reg <= sadd(ma, mb);
            ddy_reg <= sadd(mc, mdp);
        end
    end

    // origin aligned with the tangential terms
    luiter_delay #(.W(128), .D(9)) u_org (
        .clk(clk), .en(en), .din({x0_in, y0_in}), .dout(org_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg <= sadd($signed(org_d[127:64]), -ddx_reg);
            ey_reg <= sadd($signed(org_d[63:0]), -ddy_reg);
        end
    end

    // radial factor and reciprocal setup
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= sadd(WONE, poly);
        end
    end

    assign dmag = mag62(den_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= (62'd1 << 56) + (dmag >> 1);
            dvs_reg <= dmag;
            flg_reg <= {den_reg == '0, den_reg[63]};
        end
    end

    luiter_div #(.NW(62), .DW(62), .QW(RECIP_QW)) u_recip (
        .clk(clk), .en(en), .num(num_reg), .den(dvs_reg), .quo(q)
    );

    luiter_delay #(.W(2), .D(RECIP_QW)) u_flg (
        .clk(clk), .en(en), .din(flg_reg), .dout(flg_d)
    );

    // zero denominator takes the largest value, sign restored otherwise
    assign qw = work_t'({7'b0, q});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (flg_d[1])
                icd_reg <= WLIM;
            else
                icd_reg <= flg_d[0] ? -qw : qw;
        end
    end

    luiter_delay #(.W(128), .D(RECIP_QW + 4)) u_ed (
        .clk(clk), .en(en), .din({ex_reg, ey_reg}), .dout(e_d)
    );

    // scale by the reciprocal
    luiter_mul u_nx (.clk(clk), .en(en), .a($signed(e_d[127:64])), .b(icd_reg), .p(x_out));
    luiter_mul u_ny (.clk(clk), .en(en), .a($signed(e_d[63:0])),   .b(icd_reg), .p(y_out));

    // origin passed on to the next round
    luiter_delay #(.W(128), .D(ITER_LAT - 9)) u_orgo (
        .clk(clk), .en(en), .din(org_d), .dout(org_out)
    );

    assign x0_out = $signed(org_out[127:64]);
    assign y0_out = $signed(org_out[63:0]);

endmodule

// ----- design/lens_undistort_iterative_core.sv -----
// ----------------------------------------------------------------------------
// lens_undistort_iterative_core
// Brown-Conrady point undistortion by fixed-point iteration, fully pipelined.
// ----------------------------------------------------------------------------
//   channel | signals                              | direction
//   in      | in_valid, in_stall, distorted_x/y    | item in, stall out
//   out     | out_valid, out_stall, undistorted_x/y| item out, stall in
//           | clipped                              |
//   cfg     | cfg_write, cfg_index, cfg_data       | register writes in
//
// One item per cycle unless a held output is stalled. The pipeline depth is set
// mostly by the 61-step normalize divider and the 57-step reciprocal divider of each round.
// Reset clears the valid bits and loads the register defaults; no clearing
// pass. A stall on the output freezes the whole pipeline while the output
// register holds an item; in_stall is asserted only then.
// ----------------------------------------------------------------------------
module lens_undistort_iterative_core
    import luiter_pkg::*;
#(
    parameter int ITERATIONS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [19:0]        distorted_x,
    input  logic [19:0]        distorted_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [20:0] undistorted_x,
    output logic signed [20:0] undistorted_y,
    output logic               clipped,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int LAT = NORM_LAT + ITERATIONS * ITER_LAT + PIX_LAT;

    typedef struct packed {
        logic [20:0] val;
        logic        clip;
    } pix_t;

    logic [31:0] k1_reg, k2_reg, p1_reg, p2_reg;
    logic [31:0] fx_reg, fy_reg, cx_reg, cy_reg;
    logic [31:0] fxe, fye;
    work_t       k1, k2, p1, p2;
    logic        en;
    logic [LAT-1:0] vld_reg;

    logic signed [32:0] dfx_reg, dfy_reg;
    logic [32:0]  mgx, mgy;
    logic [60:0]  nx_reg, ny_reg;
    logic [31:0]  fxd_reg, fyd_reg;
    logic [1:0]   sgn_reg, sgn_d;
    logic [60:0]  qx, qy;
    work_t        x0_reg, y0_reg;

    work_t ix  [ITERATIONS+1];
    work_t iy  [ITERATIONS+1];
    work_t ix0 [ITERATIONS+1];
    work_t iy0 [ITERATIONS+1];

    work_t px, py;
    work_t sx_reg, sy_reg;
    pix_t  ox, oy;
    logic signed [20:0] ux_reg, uy_reg;
    logic  clip_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= '0;
            k2_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
            fx_reg <= 32'd65536000;
            fy_reg <= 32'd65536000;
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_K1:  k1_reg <= cfg_data;
                REG_K2:  k2_reg <= cfg_data;
                REG_P1:  p1_reg <= cfg_data;
                REG_P2:  p2_reg <= cfg_data;
                REG_FX:  fx_reg <= cfg_data;
                REG_FY:  fy_reg <= cfg_data;
                REG_CX:  cx_reg <= cfg_data;
                REG_CY:  cy_reg <= cfg_data;
                default: k1_reg <= k1_reg;
            endcase
        end
    end

    // zero focal length acts as one lsb
    assign fxe = (fx_reg == '0) ? 32'd1 : fx_reg;
    assign fye = (fy_reg == '0) ? 32'd1 : fy_reg;

    assign k1 = work_t'($signed(k1_reg));
    assign k2 = work_t'($signed(k2_reg));
    assign p1 = work_t'($signed(p1_reg));
    assign p2 = work_t'($signed(p2_reg));

    // global advance: only a held, stalled output stops the pipe
    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // offset from the principal point
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dfx_reg <= $signed({1'b0, distorted_x, 12'b0}) - $signed({1'b0, cx_reg});
            dfy_reg <= $signed({1'b0, distorted_y, 12'b0}) - $signed({1'b0, cy_reg});
        end
    end

    assign mgx = dfx_reg[32] ? 33'(-dfx_reg) : 33'(dfx_reg);
    assign mgy = dfy_reg[32] ? 33'(-dfy_reg) : 33'(dfy_reg);

    // dividend with rounding half of the focal length
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= (61'(mgx) << 28) + 61'(fxe >> 1);
            ny_reg  <= (61'(mgy) << 28) + 61'(fye >> 1);
            fxd_reg <= fxe;
            fyd_reg <= fye;
            sgn_reg <= {dfx_reg[32], dfy_reg[32]};
        end
    end

    luiter_div #(.NW(61), .DW(32), .QW(NORM_QW)) u_nrm_x (
        .clk(clk), .en(en), .num(nx_reg), .den(fxd_reg), .quo(qx)
    );

    luiter_div #(.NW(61), .DW(32), .QW(NORM_QW)) u_nrm_y (
        .clk(clk), .en(en), .num(ny_reg), .den(fyd_reg), .quo(qy)
    );

    luiter_delay #(.W(2), .D(NORM_QW)) u_sgn (
        .clk(clk), .en(en), .din(sgn_reg), .dout(sgn_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= sgn_d[1] ? -work_t'({3'b0, qx}) : work_t'({3'b0, qx});
            y0_reg <= sgn_d[0] ? -work_t'({3'b0, qy}) : work_t'({3'b0, qy});
        end
    end

    // iteration rounds
    assign ix[0]  = x0_reg;
    assign iy[0]  = y0_reg;
    assign ix0[0] = x0_reg;
    assign iy0[0] = y0_reg;

    genvar g;
    generate
        for (g = 0; g < ITERATIONS; g++)
        begin : g_iter
            luiter_iter u_iter (
                .clk    (clk),
                .en     (en),
                .k1     (k1),
                .k2     (k2),
                .p1     (p1),
                .p2     (p2),
                .x_in   (ix[g]),
                .y_in   (iy[g]),
                .x0_in  (ix0[g]),
                .y0_in  (iy0[g]),
                .x_out  (ix[g+1]),
                .y_out  (iy[g+1]),
                .x0_out (ix0[g+1]),
                .y0_out (iy0[g+1])
            );
        end
    endgenerate

    // back to pixel units
    luiter_mul u_px (
        .clk(clk), .en(en), .a(ix[ITERATIONS]), .b(work_t'({32'b0, fxe})), .p(px)
    );
    luiter_mul u_py (
        .clk(clk), .en(en), .a(iy[ITERATIONS]), .b(work_t'({32'b0, fye})), .p(py)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= sadd(px, work_t'({32'b0, cx_reg}));
            sy_reg <= sadd(py, work_t'({32'b0, cy_reg}));
        end
    end

    // round Q.16 to Q.4 and clamp to 21 bits
    function automatic pix_t to_q4(input work_t s);
        work_t       m;
        logic [63:0] r;
        logic [51:0] q;
        pix_t        res;
        m = s[63] ? -s : s;
        r = 64'(m) + 64'd2048;
        q = r[63:12];
        res.clip = 1'b0;
        if (!s[63])
        begin
            if (q > 52'd1048575)
            begin
                res.val  = 21'h0FFFFF;
                res.clip = 1'b1;
            end
            else
                res.val = q[20:0];
        end
        else
        begin
            if (q > 52'd1048576)
            begin
                res.val  = 21'h100000;
                res.clip = 1'b1;
            end
            else
                res.val = 21'(-q[20:0]);
        end
        return res;
    endfunction

    assign ox = to_q4(sx_reg);
    assign oy = to_q4(sy_reg);

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg   <= $signed(ox.val);
            uy_reg   <= $signed(oy.val);
            clip_reg <= ox.clip | oy.clip;
        end
    end

    assign out_valid     = vld_reg[LAT-1];
    assign undistorted_x = ux_reg;
    assign undistorted_y = uy_reg;
    assign clipped       = clip_reg;

    // clipped only with a coordinate at a bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |->
            (ux_reg == 21'sh0FFFFF || ux_reg == 21'sh100000 ||
             uy_reg == 21'sh0FFFFF || uy_reg == 21'sh100000))
        else $error("clipped without a saturated coordinate");

    // normalized origin stays within the divider range
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NORM_LAT-1] |->
            (x0_reg < (64'sd1 <<< 61) && x0_reg > -(64'sd1 <<< 61) &&
             y0_reg < (64'sd1 <<< 61) && y0_reg > -(64'sd1 <<< 61)))
        else $error("normalized coordinate out of range");

    // no input stall while the output register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

// ----- tb/lens_undistort_iterative_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_undistort_iterative_core_test
// Self-checking bench for the iterative point undistortion core. A bit-exact
// fixed-point predictor computes the corrected position for every accepted
// item; results are compared in order. Several register settings are run:
// identity, zero denominator, typical lenses, extreme and random values.
// ----------------------------------------------------------------------------
module lens_undistort_iterative_core_test
    import luiter_pkg::*;
;

    localparam int ROUNDS  = 5;
    localparam int LATENCY = 64 + ROUNDS * 74 + 5;

    typedef struct packed {
        logic signed [20:0] ux;
        logic signed [20:0] uy;
        logic               clp;
    } pixel_t;

    // scoreboard: predicts corrected pixels and checks them in order
    class undistort_board;
        logic [31:0] regs [8];
        pixel_t      pending [$];
        int          errors;
        int          accepted;
        int          checked;
        int          clip_seen;

        function new();
            regs[REG_K1] = 0;
            regs[REG_K2] = 0;
            regs[REG_P1] = 0;
            regs[REG_P2] = 0;
            regs[REG_FX] = 32'd65536000;
            regs[REG_FY] = 32'd65536000;
            regs[REG_CX] = 0;
            regs[REG_CY] = 0;
            errors = 0;
            accepted = 0;
            checked = 0;
            clip_seen = 0;
        endfunction

        function work_t clampw(input logic signed [65:0] v);
            if (v > 66'sd4611686018427387903)
                return WLIM;
            if (v < -66'sd4611686018427387903)
                return -WLIM;
            return v[63:0];
        endfunction

        function logic [63:0] mag(input work_t a);
            return a < 0 ? -a : a;
        endfunction

        function work_t wadd(input work_t a, input work_t b);
            logic signed [65:0] s;
            s = 66'(clampw(66'(a))) + 66'(clampw(66'(b)));
            return clampw(s);
        endfunction

        // rounded product with 28 fraction bits, ties away from zero
        function work_t wmul(input work_t a, input work_t b);
            logic [127:0] p;
            logic [127:0] r;
            work_t        m;
            p = {64'd0, mag(a)} * {64'd0, mag(b)};
            r = (p + (128'd1 << 27)) >> 28;
            if (r > 128'(WLIM))
                m = WLIM;
            else
                m = r[63:0];
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function work_t inverse(input work_t d);
            logic [63:0] md;
            logic [63:0] q;
            if (d == 0)
                return WLIM;
            md = mag(clampw(66'(d)));
            q = ((64'd1 << 56) + md / 2) / md;
            return d < 0 ? -$signed(q) : $signed(q);
        endfunction

        function work_t to_unit(input logic [19:0] d, input logic [31:0] c,
                                input logic [31:0] f);
            work_t       diff;
            logic [63:0] fm;
            logic [63:0] q;
            diff = $signed(64'({d, 12'd0})) - $signed(64'(c));
            fm = (f == 0) ? 64'd1 : 64'(f);
            q = ((mag(diff) << 28) + fm / 2) / fm;
            return diff < 0 ? -$signed(q) : $signed(q);
        endfunction

        function logic signed [20:0] to_pix(input work_t v, input logic [31:0] f,
                                            input logic [31:0] c, inout logic clp);
            work_t s;
            work_t q;
            s = wadd(wmul(v, (f == 0) ? 64'sd1 : $signed(64'(f))), $signed(64'(c)));
            q = $signed((mag(s) + 64'd2048) >> 12);
            if (s < 0)
                q = -q;
            if (q > 64'sd1048575)
            begin
                q = 64'sd1048575;
                clp = 1'b1;
            end
            if (q < -64'sd1048576)
            begin
                q = -64'sd1048576;
                clp = 1'b1;
            end
            return q[20:0];
        endfunction

        // predict the result of one accepted item
        function void note(input logic [19:0] dx, input logic [19:0] dy);
            work_t  k1, k2, p1, p2, x0, y0, x, y;
            work_t  xx, yy, xy, r2, xy2, poly, icd, ddx, ddy;
            pixel_t e;
            k1 = $signed({{32{regs[REG_K1][31]}}, regs[REG_K1]});
            k2 = $signed({{32{regs[REG_K2][31]}}, regs[REG_K2]});
            p1 = $signed({{32{regs[REG_P1][31]}}, regs[REG_P1]});
            p2 = $signed({{32{regs[REG_P2][31]}}, regs[REG_P2]});
            x0 = to_unit(dx, regs[REG_CX], regs[REG_FX]);
            y0 = to_unit(dy, regs[REG_CY], regs[REG_FY]);
            x = x0;
            y = y0;
            for (int it = 0; it < ROUNDS; it++)
            begin
                xx = wmul(x, x);
                yy = wmul(y, y);
                xy = wmul(x, y);
                r2 = wadd(xx, yy);
                xy2 = wadd(xy, xy);
                poly = wmul(wadd(wmul(k2, r2), k1), r2);
                icd = inverse(wadd(WONE, poly));
                ddx = wadd(wmul(p1, xy2), wmul(p2, wadd(r2, wadd(xx, xx))));
                ddy = wadd(wmul(p1, wadd(r2, wadd(yy, yy))), wmul(p2, xy2));
                x = wmul(wadd(x0, -ddx), icd);
                y = wmul(wadd(y0, -ddy), icd);
            end
            e.clp = 1'b0;
            e.ux = to_pix(x, regs[REG_FX], regs[REG_CX], e.clp);
            e.uy = to_pix(y, regs[REG_FY], regs[REG_CY], e.clp);
            pending = {pending, e};
            accepted++;
        endfunction

        // compare one result with the oldest prediction
        function void check(input logic signed [20:0] ux, input logic signed [20:0] uy,
                            input logic clp);
            pixel_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d clipped=%0b", $time,
                         ux, uy, clp);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (clp)
                clip_seen++;
            if (ux !== e.ux)
            begin
                $display("%0t: undistorted_x expected %0d actual %0d", $time, e.ux, ux);
                errors++;
            end
            if (uy !== e.uy)
            begin
                $display("%0t: undistorted_y expected %0d actual %0d", $time, e.uy, uy);
                errors++;
            end
            if (clp !== e.clp)
            begin
                $display("%0t: clipped expected %0b actual %0b", $time, e.clp, clp);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [19:0]        distorted_x;
    logic [19:0]        distorted_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [20:0] undistorted_x;
    logic signed [20:0] undistorted_y;
    logic               clipped;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    undistort_board board;
    bit             quiet;
    bit             held;

    lens_undistort_iterative_core #(.ITERATIONS(ROUNDS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .distorted_x   (distorted_x),
        .distorted_y   (distorted_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .undistorted_x (undistorted_x),
        .undistorted_y (undistorted_y),
        .clipped       (clipped),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.regs[idx] = val;
    endtask

    task automatic load_regs(input logic [31:0] k1, input logic [31:0] k2,
                             input logic [31:0] p1, input logic [31:0] p2,
                             input logic [31:0] fx, input logic [31:0] fy,
                             input logic [31:0] cx, input logic [31:0] cy);
        write_reg(REG_K1, k1);
        write_reg(REG_K2, k2);
        write_reg(REG_P1, p1);
        write_reg(REG_P2, p2);
        write_reg(REG_FX, fx);
        write_reg(REG_FY, fy);
        write_reg(REG_CX, cx);
        write_reg(REG_CY, cy);
    endtask

    // offer one item and hold it until accepted
    task automatic send_item(input logic [19:0] x, input logic [19:0] y);
        int g;
        in_valid <= 1'b1;
        distorted_x <= x;
        distorted_y <= y;
        do
            @(posedge clk);
        while (in_stall);
        board.note(x, y);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // random position: half anywhere, half near the principal point
    task automatic send_random();
        logic [19:0] x;
        logic [19:0] y;
        if ($urandom_range(0, 1))
        begin
            x = 20'($urandom());
            y = 20'($urandom());
        end
        else
        begin
            x = 20'((board.regs[REG_CX] >> 12) + $urandom_range(0, 8191) - 4096);
            y = 20'((board.regs[REG_CY] >> 12) + $urandom_range(0, 8191) - 4096);
        end
        send_item(x, y);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] small_coef();
        return $urandom_range(0, 32'h0A00_0000) - 32'h0500_0000;
    endfunction

    // receiver: random stalls, one long hold-off while items keep coming
    initial
    begin
        int hold;
        out_stall = 1'b0;
        held = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (!held && board != null && board.accepted >= 1200)
            begin
                held = 1'b1;
                hold = 1500;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 30) ?
                             ($urandom_range(0, 9) == 0) : 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check(undistorted_x, undistorted_y, clipped);
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        board = new();
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        distorted_x = '0;
        distorted_y = '0;
        cfg_write = 1'b0;
        cfg_index = REG_K1;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, field extremes
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'd0, 20'hFFFFF);
        send_item(20'hFFFFF, 20'd0);
        send_item(20'h55555, 20'hAAAAA);
        send_item(20'hAAAAA, 20'h55555);
        send_item(20'd1, 20'd16);
        for (int i = 0; i < 100; i++)
            send_random();
        drain();

        // denominator hits zero at unit radius
        load_regs(32'hF000_0000, 0, 0, 0, 32'd65536, 32'd65536, 0, 0);
        send_item(20'd16, 20'd0);
        send_item(20'd0, 20'd16);
        send_item(20'd16, 20'd16);
        send_item(20'd0, 20'd0);
        for (int i = 0; i < 100; i++)
            send_random();
        drain();

        // typical lens, first stretch without any idling
        load_regs(small_coef(), small_coef(),
                  $signed(small_coef()) >>> 4, $signed(small_coef()) >>> 4,
                  $urandom_range(800, 1200) << 16, $urandom_range(800, 1200) << 16,
                  32'd640 << 16, 32'd360 << 16);
        for (int i = 0; i < 500; i++)
        begin
            quiet = (i < 120);
            send_random();
        end
        quiet = 1'b0;
        drain();

        // largest values everywhere
        load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        for (int i = 0; i < 200; i++)
            send_random();
        drain();

        // most negative coefficients, zero focal length
        load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  0, 0, 0, 0);
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        for (int i = 0; i < 200; i++)
            send_random();
        drain();

        // fully random registers
        load_regs($urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom(), $urandom());
        for (int i = 0; i < 400; i++)
            send_random();
        drain();

        // another typical lens with stronger distortion
        load_regs(small_coef() <<< 2, small_coef() <<< 2, small_coef(), small_coef(),
                  $urandom_range(200, 3000) << 16, $urandom_range(200, 3000) << 16,
                  $urandom_range(0, 2000) << 16, $urandom_range(0, 2000) << 16);
        for (int i = 0; i < 400; i++)
            send_random();
        drain();

        $display("covered %0d items over seven register settings, %0d results checked",
                 board.accepted, board.checked);
        $display("%0d results saturated, one long output hold-off", board.clip_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
